>>> rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Types, character codes and the hex digit decoder for the HEX record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

  typedef enum logic [2:0] {
    PH_COLON,
    PH_COUNT,
    PH_ADDR,
    PH_TYPE,
    PH_DATA,
    PH_CSUM
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_EOF   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;

  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    logic [7:0] diff;
    r = '{ok: 1'b0, value: 4'd0};
    diff = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      diff = c - 8'h30;
      r = '{ok: 1'b1, value: diff[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      diff = c - 8'h37;
      r = '{ok: 1'b1, value: diff[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      diff = c - 8'h57;
      r = '{ok: 1'b1, value: diff[3:0]};
    end
    return r;
  endfunction

endpackage

>>> rtl/intel_hex_record_parser.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Parses HEX file text one character per beat and emits memory writes,
// an end of file marker or a format error.
// ----------------------------------------------------------------------------
//   channel  direction  handshake          payload
//   in       input      in_valid/in_ready  character, restart
//   out      output     out_valid/out_ready kind, address, data
//
// One character is taken per cycle while in_ready is high; the parser state and
// the result register are updated in the cycle of acceptance, so a result appears in the next cycle.
// A new character is taken whenever the result register is empty or being
// drained in the same cycle. Reset clears the parser to await a colon.
// After end of file or a format error, characters are consumed silently until
// a restart beat.
module intel_hex_record_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            character,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ihex_pkg::kind_t       kind,
  output logic [15:0]           address,
  output logic [7:0]            data
);
  import ihex_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  nibble_count, nibble_count_next;
  logic [11:0] high_digits, high_digits_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] write_address, write_address_next;
  logic [7:0]  record_type, record_type_next;
  logic        halted, halted_next;

  logic        emit;
  kind_t       emit_kind;
  logic [15:0] emit_address;
  logic [7:0]  emit_data;

  logic        accept;
  hex_digit_t  digit;
  logic        last_digit;
  logic [15:0] value;
  logic [7:0]  bytes_dec;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign digit    = hex_decode(character);
  assign value    = {high_digits, digit.value};
  assign bytes_dec = bytes_left - 8'd1;
  assign last_digit = (phase == PH_ADDR) ? (nibble_count == 2'd3) : (nibble_count == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_COLON;
      nibble_count  <= 2'd0;
      high_digits   <= 12'd0;
      bytes_left    <= 8'd0;
      write_address <= 16'd0;
      record_type   <= 8'd0;
      halted        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      nibble_count  <= nibble_count_next;
      high_digits   <= high_digits_next;
      bytes_left    <= bytes_left_next;
      write_address <= write_address_next;
      record_type   <= record_type_next;
      halted        <= halted_next;
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind    <= emit_kind;
      address <= emit_address;
      data    <= emit_data;
    end
  end

  always_comb begin
    phase_next         = phase;
    nibble_count_next  = nibble_count;
    high_digits_next   = high_digits;
    bytes_left_next    = bytes_left;
    write_address_next = write_address;
    record_type_next   = record_type;
    halted_next        = halted;
    emit               = 1'b0;
    emit_kind          = KIND_ERROR;
    emit_address       = 16'd0;
    emit_data          = 8'd0;

    if (accept) begin
      if (restart) begin
        phase_next         = PH_COLON;
        nibble_count_next  = 2'd0;
        high_digits_next   = 12'd0;
        bytes_left_next    = 8'd0;
        write_address_next = 16'd0;
        record_type_next   = 8'd0;
        halted_next        = 1'b0;
      end else if (!halted) begin
        if (phase == PH_COLON) begin
          if (character == CHAR_COLON) begin
            phase_next        = PH_COUNT;
            nibble_count_next = 2'd0;
            high_digits_next  = 12'd0;
          end else if (!(character inside {CHAR_CR, CHAR_LF})) begin
            emit        = 1'b1;
            halted_next = 1'b1;
          end
        end else if (!digit.ok) begin
          // Any non-hex character inside a record, a colon included, is fatal.
          emit              = 1'b1;
          halted_next       = 1'b1;
          phase_next        = PH_COLON;
          nibble_count_next = 2'd0;
          high_digits_next  = 12'd0;
        end else if (!last_digit) begin
          high_digits_next  = value[11:0];
          nibble_count_next = nibble_count + 2'd1;
        end else begin
          nibble_count_next = 2'd0;
          high_digits_next  = 12'd0;
          case (phase)
            PH_COUNT: begin
              bytes_left_next = value[7:0];
              phase_next      = PH_ADDR;
            end
            PH_ADDR: begin
              write_address_next = value;
              phase_next         = PH_TYPE;
            end
            PH_TYPE: begin
              record_type_next = value[7:0];
              if (value[7:0] == TYPE_EOF) begin
                emit        = 1'b1;
                emit_kind   = KIND_EOF;
                halted_next = 1'b1;
                phase_next  = PH_COLON;
              end else begin
                phase_next = (bytes_left == 8'd0) ? PH_CSUM : PH_DATA;
              end
            end
            PH_DATA: begin
              if (record_type == TYPE_DATA) begin
                emit               = 1'b1;
                emit_kind          = KIND_WRITE;
                emit_address       = write_address;
                emit_data          = value[7:0];
                write_address_next = write_address + 16'd1;
              end
              bytes_left_next = bytes_dec;
              if (bytes_dec == 8'd0) begin
                phase_next = PH_CSUM;
              end
            end
            default: begin
              phase_next = PH_COLON;
            end
          endcase
        end
      end
    end
  end

endmodule

>>> sim/intel_hex_record_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_parser_test
// Feeds HEX file text to the record parser one character per beat and
// checks every memory write, end of file marker and format error it gives
// against a cycle-free model of the parser kept in a small scoreboard.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_test;
  import ihex_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BEATS = 1600;
  localparam int HOLD_CYCLES  = 250;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  data;
  } parse_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       rs;
  } text_beat_t;

  // Tracks the parser state from accepted input beats and holds the
  // results that the parser still owes.
  class hex_record_board;
    parse_result_t owed_q[$];
    int            errors;
    int            beats_in;
    phase_t        ph;
    logic [1:0]    nib;
    logic [11:0]   hi;
    logic [7:0]    left;
    logic [15:0]   waddr;
    logic [7:0]    rtype;
    logic          stopped;

    function new();
      errors   = 0;
      beats_in = 0;
      clear();
    endfunction

    function void clear();
      ph      = PH_COLON;
      nib     = 2'd0;
      hi      = 12'd0;
      left    = 8'd0;
      waddr   = 16'd0;
      rtype   = 8'd0;
      stopped = 1'b0;
    endfunction

    function int pending_count();
      return owed_q.size();
    endfunction

    function bit digit_of(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= "0" && c <= "9") begin
        v = 4'(c - "0");
        return 1'b1;
      end
      if (c >= "A" && c <= "F") begin
        v = 4'(c - "A" + 8'd10);
        return 1'b1;
      end
      if (c >= "a" && c <= "f") begin
        v = 4'(c - "a" + 8'd10);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void owe(input kind_t k, input logic [15:0] a, input logic [7:0] d);
      parse_result_t r;
      r.kind    = k;
      r.address = a;
      r.data    = d;
      owed_q = {owed_q, r};
    endfunction

    function void format_error();
      stopped = 1'b1;
      ph      = PH_COLON;
      nib     = 2'd0;
      hi      = 12'd0;
      owe(KIND_ERROR, 16'd0, 8'd0);
    endfunction

    function void note_beat(input logic [7:0] c, input logic rs);
      logic [3:0]  v;
      logic [15:0] value;
      int          need;
      beats_in++;
      if (rs) begin
        clear();
        return;
      end
      if (stopped) return;
      if (ph == PH_COLON) begin
        if (c == CHAR_CR || c == CHAR_LF) return;
        if (c != CHAR_COLON) begin
          format_error();
          return;
        end
        ph  = PH_COUNT;
        nib = 2'd0;
        hi  = 12'd0;
        return;
      end
      if (!digit_of(c, v)) begin
        format_error();
        return;
      end
      need = (ph == PH_ADDR) ? 4 : 2;
      if (int'(nib) + 1 < need) begin
        hi  = {hi[7:0], v};
        nib = nib + 2'd1;
        return;
      end
      value = {hi, v};
      nib   = 2'd0;
      hi    = 12'd0;
      case (ph)
        PH_COUNT: begin
          left = value[7:0];
          ph   = PH_ADDR;
        end
        PH_ADDR: begin
          waddr = value;
          ph    = PH_TYPE;
        end
        PH_TYPE: begin
          rtype = value[7:0];
          if (rtype == TYPE_EOF) begin
            stopped = 1'b1;
            ph      = PH_COLON;
            owe(KIND_EOF, 16'd0, 8'd0);
          end else begin
            ph = (left == 8'd0) ? PH_CSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          if (rtype == TYPE_DATA) begin
            owe(KIND_WRITE, waddr, value[7:0]);
            waddr = waddr + 16'd1;
          end
          left = left - 8'd1;
          if (left == 8'd0) ph = PH_CSUM;
        end
        default: ph = PH_COLON;
      endcase
    endfunction

    function void check_result(input kind_t k, input logic [15:0] a, input logic [7:0] d);
      parse_result_t e;
      if (owed_q.size() == 0) begin
        $error("unexpected result: kind %0d address %h data %h", k, a, d);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (k !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, k);
        errors++;
      end
      if (a !== e.address) begin
        $error("address: expected %h, actual %h", e.address, a);
        errors++;
      end
      if (d !== e.data) begin
        $error("data: expected %h, actual %h", e.data, d);
        errors++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  character = 8'd0;
  logic        restart   = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  kind_t       kind;
  logic [15:0] address;
  logic [7:0]  data;

  hex_record_board board;
  text_beat_t      text_q[$];
  bit              calm = 1'b0;

  always #5 clk = ~clk;

  intel_hex_record_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .address   (address),
    .data      (data)
  );

  function void add_beat(input logic [7:0] c, input logic rs);
    text_beat_t b;
    b.ch = c;
    b.rs = rs;
    text_q = {text_q, b};
  endfunction

  function void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_beat(s[i], 1'b0);
  endfunction

  function logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] letter;
    if (n < 4'd10) return "0" + 8'(n);
    letter = $urandom_range(0, 1) ? "A" : "a";
    return letter + 8'(n) - 8'd10;
  endfunction

  function void add_hex(input logic [7:0] b);
    add_beat(hex_char(b[7:4]), 1'b0);
    add_beat(hex_char(b[3:0]), 1'b0);
  endfunction

  function void add_record(input int count, input logic [15:0] addr, input logic [7:0] typ);
    add_beat(CHAR_COLON, 1'b0);
    add_hex(8'(count));
    add_hex(addr[15:8]);
    add_hex(addr[7:0]);
    add_hex(typ);
    for (int i = 0; i < count; i++) add_hex(8'($urandom_range(0, 255)));
    add_hex(8'($urandom_range(0, 255)));
  endfunction

  function void cut_back(input int start);
    int keep;
    keep = $urandom_range(0, text_q.size() - start - 1);
    while (text_q.size() > start + keep) void'(text_q.pop_back());
  endfunction

  function void build_text();
    int         goal;
    int         sel;
    int         cnt;
    int         start;
    logic [7:0] noise;
    // Line ends, then a data record whose two bytes wrap the address.
    add_beat(CHAR_CR, 1'b0);
    add_beat(CHAR_LF, 1'b0);
    add_text(":02fFFF0000FF00");
    // Missing colon halts; the next character is ignored.
    add_text("GX");
    add_beat(8'hff, 1'b1);
    // A colon inside a record is a bad digit.
    add_text(":0:");
    add_beat(8'h00, 1'b1);
    add_text(":00000001");
    add_beat(8'(CHAR_COLON), 1'b1);

    goal = text_q.size() + RANDOM_BEATS;
    while (text_q.size() < goal) begin
      sel   = $urandom_range(0, 99);
      cnt   = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
      start = text_q.size();
      if (sel < 68) begin
        add_record(cnt, 16'($urandom_range(0, 65535)), TYPE_DATA);
      end else if (sel < 78) begin
        add_record(cnt, 16'($urandom_range(0, 65535)), 8'($urandom_range(2, 255)));
      end else if (sel < 84) begin
        add_record($urandom_range(0, 3), 16'($urandom_range(0, 65535)), TYPE_EOF);
        add_beat(8'($urandom_range(0, 255)), 1'b0);
        add_beat(8'($urandom_range(0, 255)), 1'b1);
      end else if (sel < 94) begin
        add_record(cnt, 16'($urandom_range(0, 65535)), TYPE_DATA);
        cut_back(start);
        noise = ($urandom_range(0, 3) == 0) ? CHAR_COLON : 8'($urandom_range(0, 255));
        add_beat(noise, 1'b0);
        add_beat(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        add_record(cnt, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        cut_back(start);
        add_beat(8'($urandom_range(0, 255)), 1'b1);
      end
      case ($urandom_range(0, 3))
        1: begin
          add_beat(CHAR_CR, 1'b0);
          add_beat(CHAR_LF, 1'b0);
        end
        2: add_beat(CHAR_LF, 1'b0);
        3: add_beat(CHAR_CR, 1'b0);
        default: ;
      endcase
    end
  endfunction

  // Holds the beat until the parser takes it, then books it in the scoreboard.
  task automatic send_beat(input text_beat_t b);
    in_valid  <= 1'b1;
    character <= b.ch;
    restart   <= b.rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_beat(b.ch, b.rs);
  endtask

  initial begin : stimulus
    int calm_from;
    int pause_at;
    board = new();
    build_text();
    calm_from = text_q.size() * 9 / 10;
    pause_at  = text_q.size() / 2;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (text_q[i]) begin
      send_beat(text_q[i]);
      calm = (i >= calm_from);
      if (i == pause_at) begin
        // Let the parser drain completely before going on.
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending_count() != 0);
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending_count() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : drain
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_valid && out_ready) board.check_result(kind, address, data);
      // One long hold-off so the result register fills and the input stalls.
      if (!held && board.beats_in >= 400) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
